// ===== hw/rtl/argm_pkg.sv =====
// Shared constants, types and helper functions for the audio resample gain mixer.
`default_nettype none

package argm_pkg;

    // Fixed-point layout of the resampling phase.
    localparam int FRAC_BITS   = 10;
    localparam int PHASE_W     = 17;
    localparam int ONE_POS     = 1 << FRAC_BITS;
    localparam int MIN_STEP    = 16;
    localparam int MAX_RESULTS = 64;
    localparam int COUNT_W     = $clog2(MAX_RESULTS);

    // Field widths.
    localparam int RAW_W     = 16;
    localparam int FRAMES_W  = 16;
    localparam int GAIN_W    = 12;
    localparam int STEP_W    = 16;
    localparam int SAMPLE_W  = 17;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int CONTRIB_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Sample format codes.
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S8  = 2'd1;
    localparam logic [1:0] FMT_U16 = 2'd2;
    localparam logic [1:0] FMT_S16 = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_STEREO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_STEREO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INCREMENT = 3'd5;

    // Load strobes for the shared gain multiplier.
    typedef struct packed {
        logic load_left;
        logic load_right;
    } mul_ctrl_t;

    // Removes the format center from a raw sample.
    function automatic logic signed [SAMPLE_W-1:0] centre(
        input logic [1:0]       fmt,
        input logic [RAW_W-1:0] raw
    );
        logic signed [SAMPLE_W-1:0] val;
        case (fmt)
            FMT_U8:  val = $signed({9'd0, raw[7:0]}) - 17'sd127;
            FMT_S8:  val = SAMPLE_W'($signed(raw[7:0]));
            FMT_U16: val = $signed({1'b0, raw}) - 17'sd32767;
            FMT_S16: val = SAMPLE_W'($signed(raw));
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/argm_frame_if.sv =====
// Source frame channel: valid/ready handshake with one raw frame per transfer.
`default_nettype none

interface argm_frame_if;
    logic                           valid;
    logic                           ready;
    logic [argm_pkg::RAW_W-1:0]     raw_left;
    logic [argm_pkg::RAW_W-1:0]     raw_right;
    logic                           start_of_call;
    logic [argm_pkg::FRAMES_W-1:0]  frames_wanted;
    logic                           last_source_frame;

    modport source (
        output valid, raw_left, raw_right, start_of_call, frames_wanted, last_source_frame,
        input  ready
    );
    modport sink (
        input  valid, raw_left, raw_right, start_of_call, frames_wanted, last_source_frame,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/argm_contrib_if.sv =====
// Result channel: valid/ready handshake with one output frame contribution per transfer.
`default_nettype none

interface argm_contrib_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [argm_pkg::CONTRIB_W-1:0] contribution_left;
    logic signed [argm_pkg::CONTRIB_W-1:0] contribution_right;
    logic                                  last_of_item;
    logic [argm_pkg::FRAMES_W-1:0]         frames_written;
    logic [argm_pkg::FRAMES_W-1:0]         next_source_index;
    logic                                  call_done;

    modport source (
        output valid, contribution_left, contribution_right, last_of_item,
               frames_written, next_source_index, call_done,
        input  ready
    );
    modport sink (
        input  valid, contribution_left, contribution_right, last_of_item,
               frames_written, next_source_index, call_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/audio_resample_gain_mixer.sv =====
// Top level of the nearest-neighbor audio resampler with stereo gain.
// Usage:
// Source frames arrive on the "frames" channel and output frame contributions leave on
// the "contrib" channel; both use valid/ready and a transfer happens when both are high.
// Configuration registers are written through cfg_write_en, cfg_index and cfg_data while
// the block is idle; indexes follow the register list (format, source stereo, destination
// stereo, left gain, right gain, step increment).
// Each accepted frame runs through a small sequencer: the one shared multiplier forms
// the left product, then the right product, a scale step shifts and saturates, then
// one output frame per cycle is produced while the receiver does not stall, up to 64.
// The frame channel is ready only while the sequencer is idle; it is ready again while
// the last result still sits in the output register.
// When the receiver stalls, the output register holds its result and the sequencer
// waits. Reset clears the call state, so frames are ignored until a start of call
// arrives, and restores the configuration defaults (signed 16 bit, mono source,
// stereo destination, unity gains, unity step).
`default_nettype none

module audio_resample_gain_mixer #(
    parameter int MIX_BITS = 28
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [argm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [argm_pkg::CFG_DATA_W-1:0]      cfg_data,
    argm_frame_if.sink                                frames,
    argm_contrib_if.source                            contrib
);

    // Shift that brings a product to the mix scale for 8-bit and 16-bit formats.
    localparam int SHIFT8  = MIX_BITS - 8 - argm_pkg::FRAC_BITS;
    localparam int SHIFT16 = MIX_BITS - 16 - argm_pkg::FRAC_BITS;
    localparam int SHIFT_W = $clog2(SHIFT8 + 1);
    localparam int SUM_W   = argm_pkg::PROD_W + 1;
    localparam int WIDE_W  = SUM_W + SHIFT8;
    localparam int PW      = argm_pkg::PHASE_W;
    localparam int FW      = argm_pkg::FRAMES_W;
    localparam int CW      = argm_pkg::CONTRIB_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_SCALE,
        ST_EMIT,
        ST_STATUS
    } state_t;

    // Configuration registers.
    logic [1:0]                      fmt_reg;
    logic                            src_stereo_reg;
    logic                            dst_stereo_reg;
    logic [argm_pkg::GAIN_W-1:0]     left_gain_reg;
    logic [argm_pkg::GAIN_W-1:0]     right_gain_reg;
    logic [argm_pkg::STEP_W-1:0]     step_reg;

    // Sequencer and call state.
    state_t                          state_reg;
    logic [PW-1:0]                   phase_reg;
    logic [FW-1:0]                   frames_left_reg;
    logic [FW-1:0]                   frames_done_reg;
    logic [FW-1:0]                   source_count_reg;
    logic [argm_pkg::COUNT_W-1:0]    n_reg;
    logic [argm_pkg::RAW_W-1:0]      raw_left_reg;
    logic [argm_pkg::RAW_W-1:0]      raw_right_reg;
    logic                            last_reg;
    logic signed [CW-1:0]            cl_reg;
    logic signed [CW-1:0]            cr_reg;

    // Output register.
    logic                            out_valid_reg;
    logic signed [CW-1:0]            out_left_reg;
    logic signed [CW-1:0]            out_right_reg;
    logic                            out_last_reg;
    logic [FW-1:0]                   out_written_reg;
    logic [FW-1:0]                   out_index_reg;
    logic                            out_done_reg;

    // Multiplier hookup.
    argm_pkg::mul_ctrl_t                 mul_ctrl;
    logic signed [argm_pkg::SAMPLE_W-1:0] left_val;
    logic signed [argm_pkg::SAMPLE_W-1:0] right_val;
    logic signed [argm_pkg::SAMPLE_W-1:0] mul_sample;
    logic [argm_pkg::GAIN_W-1:0]          mul_gain;
    logic signed [argm_pkg::PROD_W-1:0]   left_prod;
    logic signed [argm_pkg::PROD_W-1:0]   right_prod;

    // Scaling.
    logic                            mix_mono;
    logic [SHIFT_W-1:0]              base_shift;
    logic [SHIFT_W-1:0]              left_shift;
    logic signed [SUM_W-1:0]         left_sum;
    logic signed [WIDE_W-1:0]        wide_left;
    logic signed [WIDE_W-1:0]        wide_right;

    // Resampling step.
    logic [argm_pkg::STEP_W-1:0]     step_eff;
    logic [PW-1:0]                   phase_new;
    logic [FW-1:0]                   frames_left_dec;
    logic [FW-1:0]                   frames_done_inc;
    logic [PW-1:0]                   index_raw;
    logic [PW-1:0]                   index_lim;
    logic [PW-1:0]                   index_out;
    logic                            in_loop;
    logic                            final_out;
    logic                            out_free;
    logic [FW-1:0]                   call_frames;

    function automatic logic signed [CW-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-CW:0] top;
        logic signed [CW-1:0] res;
        top = v[WIDE_W-1:CW-1];
        if ((&top) || !(|top))
        begin
            res = v[CW-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            res = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= argm_pkg::FMT_S16;
            src_stereo_reg <= 1'b0;
            dst_stereo_reg <= 1'b1;
            left_gain_reg  <= argm_pkg::GAIN_W'(1024);
            right_gain_reg <= argm_pkg::GAIN_W'(1024);
            step_reg       <= argm_pkg::STEP_W'(1024);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                argm_pkg::REG_SAMPLE_FORMAT:  fmt_reg        <= cfg_data[1:0];
                argm_pkg::REG_SOURCE_STEREO:  src_stereo_reg <= cfg_data[0];
                argm_pkg::REG_DEST_STEREO:    dst_stereo_reg <= cfg_data[0];
                argm_pkg::REG_LEFT_GAIN:      left_gain_reg  <= cfg_data[argm_pkg::GAIN_W-1:0];
                argm_pkg::REG_RIGHT_GAIN:     right_gain_reg <= cfg_data[argm_pkg::GAIN_W-1:0];
                argm_pkg::REG_STEP_INCREMENT: step_reg       <= cfg_data[argm_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // The multiplier takes the left operands in the MUL_L state and the right ones in the MUL_R state.
    assign left_val  = argm_pkg::centre(fmt_reg, raw_left_reg);
    assign right_val = src_stereo_reg ? argm_pkg::centre(fmt_reg, raw_right_reg) : left_val;

    always_comb
    begin
        mul_ctrl.load_left  = (state_reg == ST_MUL_L);
        mul_ctrl.load_right = (state_reg == ST_MUL_R);
        mul_sample          = (state_reg == ST_MUL_R) ? right_val : left_val;
        mul_gain            = (state_reg == ST_MUL_R) ? right_gain_reg : left_gain_reg;
    end

    argm_gain_unit u_gain (
        .clk        (clk),
        .ctrl       (mul_ctrl),
        .sample     (mul_sample),
        .gain       (mul_gain),
        .left_prod  (left_prod),
        .right_prod (right_prod)
    );

    // A stereo source into a mono destination sums both products and shifts one less.
    assign mix_mono   = src_stereo_reg && !dst_stereo_reg;
    assign base_shift = fmt_reg[1] ? SHIFT_W'(SHIFT16) : SHIFT_W'(SHIFT8);
    assign left_shift = mix_mono ? base_shift - SHIFT_W'(1) : base_shift;
    assign left_sum   = mix_mono ? SUM_W'(left_prod) + SUM_W'(right_prod) : SUM_W'(left_prod);
    assign wide_left  = WIDE_W'(left_sum) <<< left_shift;
    assign wide_right = WIDE_W'(right_prod) <<< base_shift;

    // One output frame per cycle while out_free: advance the phase, count down, find the source index.
    assign step_eff = (step_reg < argm_pkg::STEP_W'(argm_pkg::MIN_STEP))
                      ? argm_pkg::STEP_W'(argm_pkg::MIN_STEP) : step_reg;
    assign phase_new       = phase_reg + PW'(step_eff);
    assign frames_left_dec = frames_left_reg - FW'(1);
    assign frames_done_inc = frames_done_reg + FW'(1);
    assign index_lim       = PW'(source_count_reg) + PW'(1);
    assign index_raw       = PW'(source_count_reg) + PW'(phase_new[PW-1:argm_pkg::FRAC_BITS]);
    assign index_out       = (last_reg && (index_raw > index_lim)) ? index_lim : index_raw;
    assign in_loop         = (phase_reg < PW'(argm_pkg::ONE_POS));
    assign final_out       = (phase_new >= PW'(argm_pkg::ONE_POS))
                             || (frames_left_dec == '0)
                             || (n_reg == argm_pkg::COUNT_W'(argm_pkg::MAX_RESULTS - 1));
    assign out_free        = !out_valid_reg || contrib.ready;
    assign call_frames     = frames.start_of_call ? frames.frames_wanted : frames_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= '0;
            frames_left_reg  <= '0;
            frames_done_reg  <= '0;
            source_count_reg <= '0;
            n_reg            <= '0;
            raw_left_reg     <= '0;
            raw_right_reg    <= '0;
            last_reg         <= 1'b0;
            cl_reg           <= '0;
            cr_reg           <= '0;
            out_valid_reg    <= 1'b0;
            out_left_reg     <= '0;
            out_right_reg    <= '0;
            out_last_reg     <= 1'b0;
            out_written_reg  <= '0;
            out_index_reg    <= '0;
            out_done_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && contrib.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (frames.valid)
                    begin
                        raw_left_reg  <= frames.raw_left;
                        raw_right_reg <= frames.raw_right;
                        last_reg      <= frames.last_source_frame;
                        n_reg         <= '0;
                        if (frames.start_of_call)
                        begin
                            phase_reg        <= '0;
                            frames_done_reg  <= '0;
                            source_count_reg <= '0;
                            frames_left_reg  <= frames.frames_wanted;
                        end
                        // Without an active call the frame is dropped with no result.
                        if (call_frames != '0)
                        begin
                            state_reg <= ST_MUL_L;
                        end
                    end
                end
                ST_MUL_L:
                begin
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    cl_reg    <= sat32(wide_left);
                    cr_reg    <= dst_stereo_reg ? sat32(wide_right) : '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (in_loop)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg   <= 1'b1;
                            out_left_reg    <= cl_reg;
                            out_right_reg   <= cr_reg;
                            out_last_reg    <= final_out;
                            out_written_reg <= frames_done_inc;
                            out_index_reg   <= index_out[FW-1:0];
                            out_done_reg    <= (frames_left_dec == '0) || (last_reg && final_out);
                            frames_done_reg <= frames_done_inc;
                            n_reg           <= n_reg + argm_pkg::COUNT_W'(1);
                            phase_reg       <= phase_new;
                            frames_left_reg <= frames_left_dec;
                            if (final_out)
                            begin
                                state_reg <= ST_IDLE;
                                if (frames_left_dec != '0)
                                begin
                                    if (phase_new >= PW'(argm_pkg::ONE_POS))
                                    begin
                                        phase_reg <= phase_new - PW'(argm_pkg::ONE_POS);
                                    end
                                    source_count_reg <= source_count_reg + FW'(1);
                                    if (last_reg)
                                    begin
                                        frames_left_reg <= '0;
                                    end
                                end
                            end
                        end
                    end
                    else
                    begin
                        // The frame is skipped; a last frame still reports the end of the call.
                        phase_reg        <= phase_reg - PW'(argm_pkg::ONE_POS);
                        source_count_reg <= source_count_reg + FW'(1);
                        if (last_reg)
                        begin
                            frames_left_reg <= '0;
                            state_reg       <= ST_STATUS;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_STATUS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_left_reg    <= '0;
                        out_right_reg   <= '0;
                        out_last_reg    <= 1'b1;
                        out_written_reg <= frames_done_reg;
                        out_index_reg   <= source_count_reg;
                        out_done_reg    <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign frames.ready               = (state_reg == ST_IDLE);
    assign contrib.valid              = out_valid_reg;
    assign contrib.contribution_left  = out_left_reg;
    assign contrib.contribution_right = out_right_reg;
    assign contrib.last_of_item       = out_last_reg;
    assign contrib.frames_written     = out_written_reg;
    assign contrib.next_source_index  = out_index_reg;
    assign contrib.call_done          = out_done_reg;

    // A frame only reaches the emit step with output frames still owed.
    a_emit_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> frames_left_reg != '0)
        else $error("emit step entered with no frames left");

    // The status result is only sent once the call has been closed.
    a_status_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STATUS |-> frames_left_reg == '0)
        else $error("status result pending while the call is still open");

    // The result that ends a call is always the final one of its frame.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("call_done without last_of_item");

    // The right product always follows the left one on the shared multiplier.
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL_L |=> state_reg == ST_MUL_R)
        else $error("multiplier sequence broken");

endmodule

`default_nettype wire

// ===== hw/rtl/argm_gain_unit.sv =====
// Shared sample-by-gain multiplier with registered left and right products.
`default_nettype none

module argm_gain_unit (
    input  wire logic                                clk,
    input  wire argm_pkg::mul_ctrl_t                 ctrl,
    input  wire logic signed [argm_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [argm_pkg::GAIN_W-1:0]          gain,
    output logic signed [argm_pkg::PROD_W-1:0]        left_prod,
    output logic signed [argm_pkg::PROD_W-1:0]        right_prod
);

    logic signed [argm_pkg::PROD_W-1:0] product;

    // The gain is unsigned, so it enters the signed multiply with a zero on top.
    assign product = argm_pkg::PROD_W'(sample * $signed({1'b0, gain}));

    always_ff @(posedge clk)
    begin
        if (ctrl.load_left)
        begin
            left_prod <= product;
        end
        if (ctrl.load_right)
        begin
            right_prod <= product;
        end
    end

endmodule

`default_nettype wire

// ===== verif/audio_resample_gain_mixer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the audio resample gain mixer: a directed table, then random calls.
module audio_resample_gain_mixer_tb;
    import argm_pkg::*;

    localparam int MIX_BITS       = 28;
    // Margin that lets a frame which yields nothing finish inside the sequencer.
    localparam int IDLE_SETTLE    = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_FRAMES   = 56;

    // One source frame as it crosses the frame channel.
    typedef struct packed {
        logic [RAW_W-1:0]    raw_left;
        logic [RAW_W-1:0]    raw_right;
        logic                start_of_call;
        logic [FRAMES_W-1:0] frames_wanted;
        logic                last_source_frame;
    } src_frame_t;

    // One output frame contribution as it crosses the result channel.
    typedef struct packed {
        logic signed [CONTRIB_W-1:0] left;
        logic signed [CONTRIB_W-1:0] right;
        logic                        last_of_item;
        logic [FRAMES_W-1:0]         frames_written;
        logic [FRAMES_W-1:0]         next_index;
        logic                        call_done;
    } out_frame_t;

    // Rows of the directed table: a register write, a frame checked against the
    // predictor, or a frame whose single result is typed in by hand.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICTED,
        ROW_TYPED
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        src_frame_t             frame;
        out_frame_t             typed;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    argm_frame_if   frames_ch ();
    argm_contrib_if contrib_ch ();

    audio_resample_gain_mixer #(
        .MIX_BITS (MIX_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frames       (frames_ch),
        .contrib      (contrib_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the configuration registers, starting from the reset defaults.
    logic [1:0]          m_fmt        = FMT_S16;
    logic                m_src_stereo = 1'b0;
    logic                m_dst_stereo = 1'b1;
    logic [GAIN_W-1:0]   m_gain_l     = 12'd1024;
    logic [GAIN_W-1:0]   m_gain_r     = 12'd1024;
    logic [STEP_W-1:0]   m_step       = 16'd1024;

    // Shadow of the resampler state: phase in Q10 relative to the incoming frame,
    // frames still owed in this call, frames produced, and source frames used.
    int unsigned         m_phase     = 0;
    logic [FRAMES_W-1:0] m_left      = '0;
    logic [FRAMES_W-1:0] m_done      = '0;
    logic [FRAMES_W-1:0] m_src_count = '0;

    out_frame_t pending_contribs[$];
    dir_row_t   dir_rows[$];

    int errors         = 0;
    int frames_sent    = 0;
    int active_frames  = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Raw sample bits with the format center removed.
    function automatic longint centred(input logic [1:0] fmt, input logic [RAW_W-1:0] raw);
        case (fmt)
            FMT_U8:  return longint'(raw[7:0]) - 127;
            FMT_S8:  return longint'($signed(raw[7:0]));
            FMT_U16: return longint'(raw) - 32767;
            default: return longint'($signed(raw));
        endcase
    endfunction

    // Saturation to the signed 32-bit contribution range. With the default mix
    // width the products never come near it, but the block must still clip.
    function automatic logic signed [CONTRIB_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[CONTRIB_W-1:0];
    endfunction

    // Works out every output frame that one accepted source frame causes and,
    // when asked, queues them. in_call tells whether the frame fell in a live call.
    function automatic void resample_frame(input src_frame_t f, input bit enqueue,
                                           output bit in_call);
        int unsigned stp;
        int unsigned lim;
        int unsigned idx;
        int          shift;
        longint      lv;
        longint      rv;
        longint      cl;
        longint      cr;
        longint      scale;
        longint      gl;
        longint      gr;
        out_frame_t  r;
        out_frame_t  outs[$];

        stp   = (m_step < MIN_STEP) ? MIN_STEP : m_step;
        shift = m_fmt[1] ? (MIX_BITS - 16 - FRAC_BITS) : (MIX_BITS - 8 - FRAC_BITS);
        scale = longint'(1) << shift;
        gl    = longint'(m_gain_l);
        gr    = longint'(m_gain_r);
        lv    = centred(m_fmt, f.raw_left);
        rv    = m_src_stereo ? centred(m_fmt, f.raw_right) : lv;

        if (f.start_of_call) begin
            m_phase     = 0;
            m_done      = '0;
            m_src_count = '0;
            m_left      = f.frames_wanted;
        end
        in_call = (m_left != 0);
        if (!in_call)
            return;

        if (!m_dst_stereo) begin
            // Stereo folded to mono is summed and shifted one place less.
            if (m_src_stereo)
                cl = (lv * gl + rv * gr) * (scale / 2);
            else
                cl = lv * gl * scale;
            cr = 0;
        end else begin
            cl = lv * gl * scale;
            cr = rv * gr * scale;
        end

        lim = m_src_count + 1;
        while (m_phase < ONE_POS && m_left != 0 && outs.size() < MAX_RESULTS) begin
            m_phase = m_phase + stp;
            m_left  = m_left - 1'b1;
            m_done  = m_done + 1'b1;
            idx = m_src_count + (m_phase >> FRAC_BITS);
            if (f.last_source_frame && idx > lim)
                idx = lim;
            r.left           = clip32(cl);
            r.right          = clip32(cr);
            r.last_of_item   = 1'b0;
            r.frames_written = m_done;
            r.next_index     = idx[FRAMES_W-1:0];
            r.call_done      = (m_left == 0);
            outs.push_back(r);
        end

        if (m_left != 0) begin
            if (m_phase >= ONE_POS)
                m_phase = m_phase - ONE_POS;
            m_src_count = m_src_count + 1'b1;
            if (f.last_source_frame) begin
                m_left = '0;
                if (outs.size() == 0) begin
                    // Source ran out without producing a frame: one status result.
                    idx = lim - 1 + ((m_phase + ONE_POS) >> FRAC_BITS);
                    if (idx > lim)
                        idx = lim;
                    r                = '0;
                    r.frames_written = m_done;
                    r.next_index     = idx[FRAMES_W-1:0];
                    outs.push_back(r);
                end
                r = outs.pop_back();
                r.call_done = 1'b1;
                outs.push_back(r);
            end
        end
        if (outs.size() > 0) begin
            r = outs.pop_back();
            r.last_of_item = 1'b1;
            outs.push_back(r);
        end

        if (enqueue)
            foreach (outs[i])
                pending_contribs.push_back(outs[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Writes one register and mirrors it. The write enable is left high so that
    // back-to-back writes never lower and raise it in the same step; the caller
    // drops it after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            REG_SAMPLE_FORMAT:  m_fmt        = val[1:0];
            REG_SOURCE_STEREO:  m_src_stereo = val[0];
            REG_DEST_STEREO:    m_dst_stereo = val[0];
            REG_LEFT_GAIN:      m_gain_l     = val[GAIN_W-1:0];
            REG_RIGHT_GAIN:     m_gain_r     = val[GAIN_W-1:0];
            REG_STEP_INCREMENT: m_step       = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Stops sending, waits for every owed contribution, then lets a frame that
    // produces nothing finish inside the block before anything is reprogrammed.
    task automatic wait_idle();
        frames_ch.valid <= 1'b0;
        while (pending_contribs.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Presents one frame, holds it until the transfer, then predicts its results.
    // Valid is left high so a following frame can go out back to back.
    task automatic send_frame(input src_frame_t f, input bit is_typed, input out_frame_t typed);
        bit live;

        while ($urandom_range(0, 99) < send_idle_pct) begin
            frames_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frames_ch.valid             <= 1'b1;
        frames_ch.raw_left          <= f.raw_left;
        frames_ch.raw_right         <= f.raw_right;
        frames_ch.start_of_call     <= f.start_of_call;
        frames_ch.frames_wanted     <= f.frames_wanted;
        frames_ch.last_source_frame <= f.last_source_frame;
        @(posedge clk);
        while (frames_ch.ready !== 1'b1)
            @(posedge clk);

        resample_frame(f, !is_typed, live);
        if (is_typed)
            pending_contribs.push_back(typed);
        frames_sent++;
        if (live)
            active_frames++;
    endtask

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        out_frame_t want;

        contrib_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n === 1'b1 && contrib_ch.valid === 1'b1 && contrib_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_contribs.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, actual left 0x%08h right 0x%08h",
                         $time, contrib_ch.contribution_left, contrib_ch.contribution_right);
            end else begin
                want = pending_contribs.pop_front();
                check_field("contribution_left", want.left, contrib_ch.contribution_left);
                check_field("contribution_right", want.right, contrib_ch.contribution_right);
                check_field("last_of_item", 32'(want.last_of_item), 32'(contrib_ch.last_of_item));
                check_field("frames_written", 32'(want.frames_written),
                            32'(contrib_ch.frames_written));
                check_field("next_source_index", 32'(want.next_index),
                            32'(contrib_ch.next_source_index));
                check_field("call_done", 32'(want.call_done), 32'(contrib_ch.call_done));
            end
        end
    end

    // Any cycle without a transfer on either channel counts toward the timeout.
    always @(posedge clk)
    begin
        if ((frames_ch.valid === 1'b1 && frames_ch.ready === 1'b1) ||
            (contrib_ch.valid === 1'b1 && contrib_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d contributions still owed",
                     $time, WATCHDOG_LIMIT, pending_contribs.size());
            $display("audio_resample_gain_mixer_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    function automatic src_frame_t mk_frame(input logic [RAW_W-1:0] rl,
                                            input logic [RAW_W-1:0] rr,
                                            input logic st, input logic [FRAMES_W-1:0] wanted,
                                            input logic last);
        src_frame_t f;
        f.raw_left          = rl;
        f.raw_right         = rr;
        f.start_of_call     = st;
        f.frames_wanted     = wanted;
        f.last_source_frame = last;
        return f;
    endfunction

    function automatic out_frame_t mk_out(input logic signed [CONTRIB_W-1:0] l,
                                          input logic signed [CONTRIB_W-1:0] r,
                                          input logic last, input logic [FRAMES_W-1:0] fw,
                                          input logic [FRAMES_W-1:0] idx, input logic done);
        out_frame_t o;
        o.left           = l;
        o.right          = r;
        o.last_of_item   = last;
        o.frames_written = fw;
        o.next_index     = idx;
        o.call_done      = done;
        return o;
    endfunction

    function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_frame(input src_frame_t f);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_PREDICTED;
        row.frame = f;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_typed(input src_frame_t f, input out_frame_t o);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_TYPED;
        row.frame = f;
        row.typed = o;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        // Reset configuration: signed 16 bit, mono to stereo, unity gains and step.
        // Nothing is live after reset, and a start asking for zero frames starts nothing.
        row_frame(mk_frame(16'h1234, 16'h0000, 1'b0, 16'd0, 1'b0));
        row_frame(mk_frame(16'h4000, 16'h0000, 1'b1, 16'd0, 1'b0));
        // Full-scale positive, full-scale negative, then zero; one frame out per frame in.
        row_typed(mk_frame(16'h7FFF, 16'hFFFF, 1'b1, 16'd3, 1'b0),
                  mk_out(32'sd134213632, 32'sd134213632, 1'b1, 16'd1, 16'd1, 1'b0));
        row_typed(mk_frame(16'h8000, 16'h0000, 1'b0, 16'hFFFF, 1'b0),
                  mk_out(-32'sd134217728, -32'sd134217728, 1'b1, 16'd2, 16'd2, 1'b0));
        row_typed(mk_frame(16'h0000, 16'h7FFF, 1'b0, 16'd0, 1'b0),
                  mk_out(32'sd0, 32'sd0, 1'b1, 16'd3, 16'd3, 1'b1));
        // Call is over: this one is dropped.
        row_frame(mk_frame(16'h5555, 16'hAAAA, 1'b0, 16'd9, 1'b0));

        // Unsigned 8 bit stereo, largest step and gains at both ends.
        row_write(REG_STEP_INCREMENT, 16'hFFFF);
        row_write(REG_LEFT_GAIN, 16'd4095);
        row_write(REG_RIGHT_GAIN, 16'd0);
        row_write(REG_SAMPLE_FORMAT, 16'(FMT_U8));
        row_write(REG_SOURCE_STEREO, 16'd1);
        row_typed(mk_frame(16'hA5FF, 16'h3C00, 1'b1, 16'hFFFF, 1'b0),
                  mk_out(32'sd536739840, 32'sd0, 1'b1, 16'd1, 16'd63, 1'b0));
        // Last source frame with nothing to emit: status result, index clamped.
        row_typed(mk_frame(16'h1234, 16'h5678, 1'b0, 16'd0, 1'b1),
                  mk_out(32'sd0, 32'sd0, 1'b1, 16'd1, 16'd2, 1'b1));

        // Signed 8 bit stereo folded to mono; a step below the minimum acts as the
        // minimum, so the first frame gives the most results any frame can.
        row_write(REG_SAMPLE_FORMAT, 16'(FMT_S8));
        row_write(REG_DEST_STEREO, 16'd0);
        row_write(REG_RIGHT_GAIN, 16'd4095);
        row_write(REG_STEP_INCREMENT, 16'd15);
        row_frame(mk_frame(16'hFF80, 16'h0080, 1'b1, 16'd100, 1'b0));
        row_frame(mk_frame(16'h007F, 16'h807F, 1'b0, 16'd0, 1'b1));

        // Unsigned 16 bit mono to mono at twice the source rate; right gain unused.
        row_write(REG_SAMPLE_FORMAT, 16'(FMT_U16));
        row_write(REG_SOURCE_STEREO, 16'd0);
        row_write(REG_LEFT_GAIN, 16'd1024);
        row_write(REG_STEP_INCREMENT, 16'd512);
        row_frame(mk_frame(16'hFFFF, 16'h0000, 1'b1, 16'd5, 1'b0));
        row_frame(mk_frame(16'h0000, 16'hFFFF, 1'b0, 16'd0, 1'b0));
        row_frame(mk_frame(16'h7FFF, 16'h1111, 1'b0, 16'd0, 1'b0));
        // A start in the middle of a call restarts it.
        row_frame(mk_frame(16'h1234, 16'h0000, 1'b1, 16'd10, 1'b0));
        row_frame(mk_frame(16'h4321, 16'h0000, 1'b1, 16'd2, 1'b1));
        // A call whose first frame is also its last.
        row_frame(mk_frame(16'hABCD, 16'h0000, 1'b1, 16'd7, 1'b1));
    endfunction

    // ------------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------------

    // Programs every register for one phase and picks its idling pattern. The
    // phases cover each channel mapping with two formats, the gain extremes and
    // the step extremes, including steps below the minimum.
    task automatic setup_phase(input int p);
        logic [1:0]            fmt_cycle [4];
        logic [CFG_DATA_W-1:0] gl;
        logic [CFG_DATA_W-1:0] gr;
        logic [CFG_DATA_W-1:0] stp;

        fmt_cycle = '{FMT_U8, FMT_S8, FMT_U16, FMT_S16};
        gl  = 16'($urandom_range(0, 4095));
        gr  = 16'($urandom_range(0, 4095));
        stp = 16'($urandom_range(128, 2048));
        case (p)
            0: begin gl = 16'd4095; gr = 16'd4095; end
            1: begin gl = 16'd0; gr = 16'd0; end
            2: stp = 16'd16;
            3: stp = 16'($urandom_range(16, 65535));
            4: begin gl = 16'd4095; gr = 16'd0; end
            5: stp = 16'($urandom_range(0, 15));
            6: stp = 16'hFFFF;
            default: ;
        endcase

        wait_idle();
        write_reg(REG_SAMPLE_FORMAT, 16'(fmt_cycle[p % 4]));
        write_reg(REG_SOURCE_STEREO, 16'((p / 2) % 2));
        write_reg(REG_DEST_STEREO, 16'((p / 4) % 2));
        write_reg(REG_LEFT_GAIN, gl);
        write_reg(REG_RIGHT_GAIN, gr);
        write_reg(REG_STEP_INCREMENT, stp);
        cfg_write_en <= 1'b0;
        settings_used++;

        case ((p + p / 4) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Mostly well-formed calls with random samples; the rest are stray frames,
    // zero-length starts and restarts that land on a live call.
    task automatic random_calls(input int target);
        int                  base;
        int                  nfr;
        logic [FRAMES_W-1:0] wanted;
        src_frame_t          f;

        base = active_frames;
        while (active_frames - base < target) begin
            if ($urandom_range(0, 99) < 82) begin
                wanted = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                     : 16'($urandom_range(1, 48));
                nfr = $urandom_range(1, 12);
                for (int k = 0; k < nfr; k++) begin
                    f.raw_left          = 16'($urandom);
                    f.raw_right         = 16'($urandom);
                    f.start_of_call     = (k == 0);
                    f.frames_wanted     = (k == 0) ? wanted : 16'($urandom);
                    f.last_source_frame = (k == nfr - 1) && ($urandom_range(0, 9) != 0);
                    send_frame(f, 1'b0, '0);
                end
            end else begin
                f.raw_left          = 16'($urandom);
                f.raw_right         = 16'($urandom);
                f.start_of_call     = ($urandom_range(0, 2) == 0);
                f.frames_wanted     = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                f.last_source_frame = ($urandom_range(0, 3) == 0);
                send_frame(f, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        dir_row_t row;
        bit       writing;

        rst_n                        = 1'b0;
        cfg_write_en                 = 1'b0;
        cfg_index                    = '0;
        cfg_data                     = '0;
        frames_ch.valid              = 1'b0;
        frames_ch.raw_left           = '0;
        frames_ch.raw_right          = '0;
        frames_ch.start_of_call      = 1'b0;
        frames_ch.frames_wanted      = '0;
        frames_ch.last_source_frame  = 1'b0;
        contrib_ch.ready             = 1'b0;
        writing                      = 1'b0;

        build_directed();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side. Register writes are grouped,
        // and each group waits for the block to go quiet first.
        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (writing) begin
                    cfg_write_en <= 1'b0;
                    writing = 1'b0;
                    settings_used++;
                end
                send_frame(row.frame, row.kind == ROW_TYPED, row.typed);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            setup_phase(p);
            random_calls(PHASE_FRAMES);
        end

        wait_idle();
        if (pending_contribs.size() != 0) begin
            errors++;
            $display("%0t: %0d contributions never arrived", $time, pending_contribs.size());
        end

        $display("Sent %0d source frames (%0d inside live calls) across %0d register settings;",
                 frames_sent, active_frames, settings_used);
        $display("checked %0d output frame transfers, %0d mismatches.", results_seen, errors);
        if (errors == 0)
            $display("audio_resample_gain_mixer_tb OK");
        else
            $display("audio_resample_gain_mixer_tb NOT OK");
        $finish;
    end

endmodule
